// File: hdl/ctt_pkg.sv
package ctt_pkg;

    // Table geometry
    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Request kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_CLOCK = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    // Compare modes
    localparam logic [2:0] MODE_GE       = 3'd0;
    localparam logic [2:0] MODE_LE       = 3'd1;
    localparam logic [2:0] MODE_ERR_1    = 3'd2;
    localparam logic [2:0] MODE_ERR_10   = 3'd3;
    localparam logic [2:0] MODE_ERR_100  = 3'd4;
    localparam logic [2:0] MODE_ERR_1000 = 3'd5;

    // Q16.16 error limits: 1.0, 10.0, 100.0, 1000.0
    localparam logic [32:0] ERR_LIM_1    = 33'd65536;
    localparam logic [32:0] ERR_LIM_10   = 33'd655360;
    localparam logic [32:0] ERR_LIM_100  = 33'd6553600;
    localparam logic [32:0] ERR_LIM_1000 = 33'd65536000;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [CNT_W-1:0]  slot_cnt_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] base_value;
        logic signed [31:0] offset_value;
        logic [2:0]         compare_mode;
        logic [31:0]        timeout_ticks;
        logic [31:0]        time_value;
        logic [2:0]         slot_index;
        logic signed [31:0] current_value;
    } req_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] slot_out;
        logic       fired;
        logic [3:0] pending_count;
    } rsp_t;

    // Table contents seen by the evaluation logic
    typedef struct packed {
        logic [SLOTS-1:0]   waiting;
        logic               free_found;
        slot_idx_t          free_idx;
        logic               sel_waiting;
        logic signed [31:0] sel_target;
        logic [2:0]         sel_mode;
        logic [31:0]        sel_deadline;
        logic               sel_has_dl;
        logic [31:0]        clock_now;
        slot_cnt_t          total;
    } view_t;

    // Table update for one request
    typedef struct packed {
        logic               add_en;
        slot_idx_t          add_idx;
        logic signed [31:0] add_target;
        logic [2:0]         add_mode;
        logic [31:0]        add_deadline;
        logic               add_has_dl;
        logic               clear_en;
        slot_idx_t          clear_idx;
        logic               clock_en;
        logic [31:0]        clock_val;
        slot_cnt_t          total_next;
    } upd_t;

endpackage

// File: hdl/ctt_if.sv
interface ctt_req_if;
    import ctt_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ctt_rsp_if;
    import ctt_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/ctt_table.sv
module ctt_table (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [2:0]     rd_index,
    input  ctt_pkg::upd_t  upd,
    output ctt_pkg::view_t view
);
    import ctt_pkg::*;

    logic [SLOTS-1:0]   waiting_reg;
    logic [SLOTS-1:0]   waiting_next;
    logic signed [31:0] target_reg [SLOTS];
    logic [2:0]         mode_reg [SLOTS];
    logic [31:0]        deadline_reg [SLOTS];
    logic               has_dl_reg [SLOTS];
    logic [31:0]        clock_reg;
    logic [31:0]        clock_next;
    slot_cnt_t          total_reg;
    slot_cnt_t          total_next;
    slot_idx_t          sel_idx;
    logic               sel_in_range;

    assign sel_idx      = rd_index[SLOT_W-1:0];
    assign sel_in_range = (32'(rd_index) < 32'(SLOTS));

    // Find the lowest free slot and read the checked slot
    always_comb
    begin
        view.free_found = 1'b0;
        view.free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!waiting_reg[i])
            begin
                view.free_found = 1'b1;
                view.free_idx   = slot_idx_t'(i);
            end
        end
        view.waiting      = waiting_reg;
        view.sel_waiting  = sel_in_range && waiting_reg[sel_idx];
        view.sel_target   = target_reg[sel_idx];
        view.sel_mode     = mode_reg[sel_idx];
        view.sel_deadline = deadline_reg[sel_idx];
        view.sel_has_dl   = has_dl_reg[sel_idx];
        view.clock_now    = clock_reg;
        view.total        = total_reg;
    end

    // Next control state
    always_comb
    begin
        waiting_next = waiting_reg;
        if (upd.add_en)
        begin
            waiting_next[upd.add_idx] = 1'b1;
        end
        if (upd.clear_en)
        begin
            waiting_next[upd.clear_idx] = 1'b0;
        end
        clock_next = upd.clock_en ? upd.clock_val : clock_reg;
        total_next = upd.total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= '0;
            clock_reg   <= '0;
            total_reg   <= '0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            clock_reg   <= clock_next;
            total_reg   <= total_next;
        end
    end

    // Write slot contents on add
    always_ff @(posedge clk)
    begin
        if (upd.add_en)
        begin
            target_reg[upd.add_idx]   <= upd.add_target;
            mode_reg[upd.add_idx]     <= upd.add_mode;
            deadline_reg[upd.add_idx] <= upd.add_deadline;
            has_dl_reg[upd.add_idx]   <= upd.add_has_dl;
        end
    end

endmodule

// File: hdl/ctt_eval.sv
module ctt_eval (
    input  logic           go,
    input  ctt_pkg::req_t  req_in,
    input  ctt_pkg::view_t view,
    output ctt_pkg::upd_t  upd,
    output ctt_pkg::rsp_t  rsp_out
);
    import ctt_pkg::*;

    logic signed [32:0] tgt_sum;
    logic signed [31:0] tgt_sat;
    logic [32:0]        dl_sum;
    logic [31:0]        dl_sat;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic               hit;
    logic               late;
    logic               is_add;
    logic               is_clock;
    logic               is_check;
    logic               do_add;
    logic               do_clear;

    // Saturate target to signed 32 bits
    assign tgt_sum = {req_in.base_value[31], req_in.base_value}
                   + {req_in.offset_value[31], req_in.offset_value};
    always_comb
    begin
        if (tgt_sum[32] != tgt_sum[31])
        begin
            tgt_sat = tgt_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            tgt_sat = tgt_sum[31:0];
        end
    end

    // Saturate deadline to all ones
    assign dl_sum = {1'b0, view.clock_now} + {1'b0, req_in.timeout_ticks};
    assign dl_sat = dl_sum[32] ? '1 : dl_sum[31:0];

    // Compare current value with the checked slot's target
    assign diff     = {req_in.current_value[31], req_in.current_value}
                    - {view.sel_target[31], view.sel_target};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    always_comb
    begin
        case (view.sel_mode)
            MODE_GE:       hit = (req_in.current_value >= view.sel_target);
            MODE_LE:       hit = (req_in.current_value <= view.sel_target);
            MODE_ERR_1:    hit = (diff_mag < ERR_LIM_1);
            MODE_ERR_10:   hit = (diff_mag < ERR_LIM_10);
            MODE_ERR_100:  hit = (diff_mag < ERR_LIM_100);
            MODE_ERR_1000: hit = (diff_mag < ERR_LIM_1000);
            default:       hit = 1'b0;
        endcase
    end

    assign late = view.sel_has_dl && (view.clock_now >= view.sel_deadline);

    // Decode the request
    assign is_add   = (req_in.kind == KIND_ADD);
    assign is_clock = (req_in.kind == KIND_CLOCK);
    assign is_check = (req_in.kind == KIND_CHECK);
    assign do_add   = is_add && view.free_found;
    assign do_clear = is_check && view.sel_waiting && (hit || late);

    // Build the table update
    always_comb
    begin
        upd.add_en       = go && do_add;
        upd.add_idx      = view.free_idx;
        upd.add_target   = tgt_sat;
        upd.add_mode     = req_in.compare_mode;
        upd.add_deadline = dl_sat;
        upd.add_has_dl   = (req_in.timeout_ticks != '0);
        upd.clear_en     = go && do_clear;
        upd.clear_idx    = req_in.slot_index[SLOT_W-1:0];
        upd.clock_en     = go && is_clock;
        upd.clock_val    = req_in.time_value;
        if (upd.add_en)
        begin
            upd.total_next = view.total + slot_cnt_t'(1);
        end
        else if (upd.clear_en)
        begin
            upd.total_next = view.total - slot_cnt_t'(1);
        end
        else
        begin
            upd.total_next = view.total;
        end
    end

    // Build the response
    always_comb
    begin
        rsp_out.accepted      = !is_add || view.free_found;
        rsp_out.slot_out      = '0;
        if (do_add)
        begin
            rsp_out.slot_out = 3'(view.free_idx);
        end
        else if (is_check)
        begin
            rsp_out.slot_out = req_in.slot_index;
        end
        rsp_out.fired         = do_clear;
        rsp_out.pending_count = 4'(upd.total_next);
    end

endmodule

// File: hdl/condition_triggered_task_table.sv
// Condition-triggered task table: eight slots of pending tasks, each with a
// saturated Q16.16 target, a compare mode and an optional deadline. Every
// request gives exactly one response. A request is registered on entry and
// evaluated against the table from the input register; its response lands in
// an output register while the table updates on the same edge, so a new
// request can be taken every cycle. Throughput is one request per cycle
// whenever the response side keeps ready high; a stalled response holds one
// request in the input register behind it before ready drops.
module condition_triggered_task_table (
    input logic     clk,
    input logic     rst_n,
    ctt_req_if.sink req,
    ctt_rsp_if.source rsp
);
    import ctt_pkg::*;

    req_t  req_reg;
    logic  in_valid_reg;
    logic  in_valid_next;
    rsp_t  rsp_reg;
    rsp_t  rsp_calc;
    logic  out_valid_reg;
    logic  out_valid_next;
    logic  advance;
    logic  go;
    logic  take;
    view_t view;
    upd_t  upd;

    // Handshake control
    assign advance   = !out_valid_reg || rsp.ready;
    assign go        = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (go)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = advance ? go : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the request and the response
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req.payload;
        end
        if (go)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    ctt_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_index (req_reg.slot_index),
        .upd      (upd),
        .view     (view)
    );

    ctt_eval u_eval (
        .go      (go),
        .req_in  (req_reg),
        .view    (view),
        .upd     (upd),
        .rsp_out (rsp_calc)
    );

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // Checks
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(view.total) == 32'($countones(view.waiting)))
        else $error("pending count differs from waiting slots");

    a_fired_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rsp_reg.fired) |-> rsp_reg.accepted)
        else $error("fired response not marked accepted");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(req_reg)))
        else $error("stalled request lost from input register");

    a_add_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !view.free_found) |-> !upd.add_en)
        else $error("add issued with no free slot");

endmodule

// File: dv/condition_triggered_task_table_test.sv
module condition_triggered_task_table_test;
    import ctt_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 10;

    // Codes the package leaves unnamed
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [2:0] MODE_NEVER = 3'd6;
    localparam logic [2:0] MODE_SPARE = 3'd7;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ctt_req_if req_ch ();
    ctt_rsp_if rsp_ch ();

    condition_triggered_task_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Expected responses, oldest first
    rsp_t expected_rsp [$];
    int unsigned error_count = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver hold-off, started by bumping hold_seq
    int unsigned hold_seq = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    // Shadow copy of the task table
    logic               tbl_waiting  [SLOTS];
    logic signed [31:0] tbl_target   [SLOTS];
    logic [2:0]         tbl_mode     [SLOTS];
    logic [31:0]        tbl_deadline [SLOTS];
    logic               tbl_has_dl   [SLOTS];
    int unsigned        tbl_count = 0;
    logic [31:0]        tbl_clock = '0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > longint'(Q_MAX))
            return Q_MAX;
        if (v < longint'(Q_MIN))
            return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic condition_met(input logic [2:0] mode,
                                           input logic signed [31:0] cur,
                                           input logic signed [31:0] tgt);
        longint c = cur;
        longint t = tgt;
        longint d;
        d = c - t;
        if (d < 0)
            d = -d;
        case (mode)
            MODE_GE:       return c >= t;
            MODE_LE:       return c <= t;
            MODE_ERR_1:    return d < longint'(ERR_LIM_1);
            MODE_ERR_10:   return d < longint'(ERR_LIM_10);
            MODE_ERR_100:  return d < longint'(ERR_LIM_100);
            MODE_ERR_1000: return d < longint'(ERR_LIM_1000);
            default:       return 1'b0;
        endcase
    endfunction

    // Update the shadow table for one accepted request and queue its response
    task automatic record_response(input req_t r);
        rsp_t want;
        int pos;
        int s;
        logic [32:0] dl;
        want = '0;
        want.accepted = 1'b1;
        case (r.kind)
            KIND_ADD:
            begin
                pos = -1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (pos < 0 && !tbl_waiting[i])
                        pos = i;
                end
                if (pos < 0)
                begin
                    want.accepted = 1'b0;
                end
                else
                begin
                    dl = {1'b0, tbl_clock} + {1'b0, r.timeout_ticks};
                    tbl_target[pos]   = sat32(longint'(r.base_value) +
                                              longint'(r.offset_value));
                    tbl_mode[pos]     = r.compare_mode;
                    tbl_deadline[pos] = dl[32] ? 32'hFFFF_FFFF : dl[31:0];
                    tbl_has_dl[pos]   = (r.timeout_ticks != 0);
                    tbl_waiting[pos]  = 1'b1;
                    tbl_count++;
                    want.slot_out = pos[2:0];
                end
            end
            KIND_CLOCK:
                tbl_clock = r.time_value;
            KIND_CHECK:
            begin
                s = int'(r.slot_index);
                want.slot_out = r.slot_index;
                if (s < SLOTS && tbl_waiting[s])
                begin
                    if (condition_met(tbl_mode[s], r.current_value, tbl_target[s]) ||
                        (tbl_has_dl[s] && tbl_clock >= tbl_deadline[s]))
                    begin
                        tbl_waiting[s] = 1'b0;
                        tbl_count--;
                        want.fired = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        want.pending_count = tbl_count[3:0];
        expected_rsp.push_back(want);
    endtask

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        record_response(r);
    endtask

    function automatic req_t random_fields();
        req_t r;
        r.kind          = 2'($urandom_range(3));
        r.base_value    = $urandom();
        r.offset_value  = $urandom();
        r.compare_mode  = 3'($urandom_range(7));
        r.timeout_ticks = $urandom();
        r.time_value    = $urandom();
        r.slot_index    = 3'($urandom_range(7));
        r.current_value = $urandom();
        return r;
    endfunction

    // Mostly adds and checks that land near the stored targets
    function automatic req_t random_item();
        req_t r;
        int pick;
        int waiting_list [$];
        int s;
        longint lim;
        longint delta;
        r = random_fields();
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            r.kind = KIND_ADD;
            case ($urandom_range(9))
                0: begin r.base_value = Q_MAX; r.offset_value = $urandom_range(1 << 20); end
                1: begin r.base_value = Q_MIN; r.offset_value = -$urandom_range(1 << 20); end
                2, 3: r.offset_value = $urandom();
                default: r.offset_value = $signed($urandom_range(1 << 21)) - (1 << 20);
            endcase
            case ($urandom_range(9))
                0, 1, 2: r.timeout_ticks = '0;
                3, 4:    r.timeout_ticks = $urandom();
                default: r.timeout_ticks = $urandom_range(64, 1);
            endcase
        end
        else if (pick < 45)
        begin
            r.kind = KIND_CLOCK;
            case ($urandom_range(9))
                0:       r.time_value = 32'hFFFF_FFFF;
                1:       r.time_value = '0;
                2, 3:    r.time_value = $urandom();
                default: r.time_value = tbl_clock + $urandom_range(40, 1);
            endcase
        end
        else if (pick < 95)
        begin
            r.kind = KIND_CHECK;
            foreach (tbl_waiting[i])
            begin
                if (tbl_waiting[i])
                    waiting_list.push_back(i);
            end
            if (waiting_list.size() != 0 && $urandom_range(9) < 8)
            begin
                s = waiting_list[$urandom_range(waiting_list.size() - 1)];
                r.slot_index = 3'(s);
                case (tbl_mode[s])
                    MODE_ERR_10:   lim = longint'(ERR_LIM_10);
                    MODE_ERR_100:  lim = longint'(ERR_LIM_100);
                    MODE_ERR_1000: lim = longint'(ERR_LIM_1000);
                    default:       lim = longint'(ERR_LIM_1);
                endcase
                case ($urandom_range(6))
                    0: delta = lim;
                    1: delta = lim - 1;
                    2: delta = -lim;
                    3: delta = 1 - lim;
                    4: delta = 0;
                    default: delta = longint'($urandom_range(32'(2 * lim))) - lim;
                endcase
                if ($urandom_range(9) != 0)
                    r.current_value = sat32(longint'(tbl_target[s]) + delta);
            end
        end
        else
        begin
            r.kind = KIND_SPARE;
        end
        return r;
    endfunction

    task automatic send_add(input logic signed [31:0] base, input logic signed [31:0] offs,
                            input logic [2:0] mode, input logic [31:0] timeout);
        req_t r;
        r = random_fields();
        r.kind          = KIND_ADD;
        r.base_value    = base;
        r.offset_value  = offs;
        r.compare_mode  = mode;
        r.timeout_ticks = timeout;
        send_request(r);
    endtask

    task automatic send_clock(input logic [31:0] t);
        req_t r;
        r = random_fields();
        r.kind       = KIND_CLOCK;
        r.time_value = t;
        send_request(r);
    endtask

    task automatic send_check(input logic [2:0] slot, input logic signed [31:0] cur);
        req_t r;
        r = random_fields();
        r.kind          = KIND_CHECK;
        r.slot_index    = slot;
        r.current_value = cur;
        send_request(r);
    endtask

    task automatic test_empty_table();
        send_check(3'd0, $urandom());
        send_check(3'd7, $urandom());
    endtask

    // Targets clamp at both ends of Q16.16
    task automatic test_saturation();
        send_add(Q_MAX, Q_MAX, MODE_GE, '0);
        send_add(Q_MIN, Q_MIN, MODE_LE, '0);
        send_check(3'd0, Q_MAX - 1);
        send_check(3'd1, Q_MIN);
    endtask

    // Deadline clamps at the top of the clock, then a plain expiry
    task automatic test_deadlines();
        send_clock(32'hFFFF_FFF0);
        send_add($urandom(), $urandom(), MODE_NEVER, 32'hFFFF_FFFF);
        send_check(3'd1, $urandom());
        send_clock(32'hFFFF_FFFF);
        send_check(3'd1, $urandom());
        send_clock(32'd100);
        send_add($urandom(), $urandom(), MODE_SPARE, 32'd5);
        send_check(3'd1, $urandom());
        send_clock(32'd105);
        send_check(3'd1, $urandom());
    endtask

    // Error limits are strict; a difference past 32 bits must not wrap
    task automatic test_compare_modes();
        send_add(32'sh0001_0000, '0, MODE_ERR_1, '0);
        send_check(3'd1, 32'sh0002_0000);
        send_check(3'd1, 32'sh0000_0001);
        send_add(Q_MIN, '0, MODE_ERR_1000, '0);
        send_check(3'd1, Q_MAX);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < SLOTS - 1; i++)
            send_add($urandom(), $urandom(), 3'($urandom_range(7)), $urandom_range(30, 1));
    endtask

    task automatic test_unused_kind();
        req_t r;
        r = random_fields();
        r.kind = KIND_SPARE;
        send_request(r);
    endtask

    // Stall the response side for a long stretch while requests keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_seq <= hold_seq + 1;
        for (int i = 0; i < 40; i++)
            send_request(random_item());
    endtask

    task automatic test_random_mix(input int count, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < count; i++)
            send_request(random_item());
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Count down the receiver hold-off
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Compare each taken response with the oldest expectation, then drive ready
    always @(posedge clk)
    begin : check_responses
        rsp_t want;
        rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.payload;
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: unexpected response, expected none actual %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_rsp.pop_front();
                check_field("accepted", want.accepted, got.accepted);
                check_field("slot_out", want.slot_out, got.slot_out);
                check_field("fired", want.fired, got.fired);
                check_field("pending_count", want.pending_count, got.pending_count);
            end
        end
        rsp_ch.ready <= rst_n && hold_left == 0 && hold_seq == hold_seen &&
                        ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        foreach (tbl_waiting[i])
            tbl_waiting[i] = 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 32;
        recv_idle_pct = 49;
        test_empty_table();
        test_saturation();
        test_deadlines();
        test_compare_modes();
        test_table_full();
        test_unused_kind();
        test_backpressure();
        test_random_mix(330, 32, 49);
        test_random_mix(330, 49, 32);
        test_random_mix(330, 0, 0);
        req_ch.valid <= 1'b0;

        // Drain outstanding responses, then let the pipeline settle
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
